>>> design/ffca_pkg.sv
// Package for the first-fit chunk allocator: word types, command and status
// codes, sizing constants and the sequencer state type. No dependencies.
`default_nettype none

package ffca_pkg;

  localparam int STORE_BYTES = 4096;
  localparam int MIN_SPLIT   = 4;
  localparam int AW          = $clog2(STORE_BYTES);
  // Scan pointers run past the region end by up to one chunk length.
  localparam int PW          = (AW > 14) ? AW : 14;
  localparam logic [7:0] MAX_ALLOC = 8'(128 - MIN_SPLIT);
  localparam logic [7:0] USED_BIT  = 8'h80;
  localparam logic [7:0] LEN_MASK  = 8'h7F;

  localparam logic [1:0] CMD_ALLOC  = 2'd0;
  localparam logic [1:0] CMD_FREE   = 2'd1;
  localparam logic [1:0] CMD_FORMAT = 2'd2;
  localparam logic [1:0] CMD_STORE  = 2'd3;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_SPACE   = 2'd1;
  localparam logic [1:0] ST_OUT_REGION = 2'd2;
  localparam logic [1:0] ST_NOT_IN_USE = 2'd3;

  localparam logic REG_REGION_START = 1'b0;
  localparam logic REG_REGION_SIZE  = 1'b1;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [6:0]  alloc_length;
    logic [11:0] address;
    logic [7:0]  data_byte;
  } req_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [11:0] chunk_address;
  } rsp_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_EXEC,
    S_OUTER,
    S_READ,
    S_HEAD,
    S_EVAL,
    S_WRA,
    S_WRB,
    S_FREE_RD,
    S_FREE_HD,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

>>> design/ffca_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; used as the allocator's byte store.
`default_nettype none

module ffca_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> design/first_fit_chunk_allocator.sv
// Top level of the first-fit chunk allocator: command sequencer and byte store.
// Depends on ffca_pkg and ffca_ram.
//
// Usage: commands arrive as one req word on req / req_valid / req_stall and
// each gives exactly one rsp word on rsp / rsp_valid / rsp_stall. A word moves
// at a rising edge where valid is high and stall is low. The block holds one
// command at a time: req_stall stays high from acceptance until the result is
// loaded into the output register, which then waits for the receiver while
// the next command is already taken. A stalled receiver holds rsp steady and,
// once a second result is ready behind it, keeps req_stall high.
// Store and format each write one byte of the store. Allocate rejects a length
// out of range without a scan; else it visits chunk headers and, on success,
// makes one or two store writes; the scan may also give up at the start of a
// run. The scan reads one header per visit through the single read port of
// the byte store, so allocate time grows with the number of chunks passed.
// Free reads the header only when the address lies inside the region.
// Registers region_start (index 0) and region_size (index 1) are written on
// cfg_we; write them only while the block is idle. Synchronous reset returns
// the registers to 1 and 4095 and empties the pipeline; the byte store keeps
// no reset and must be formatted before the first allocate or free.
`default_nettype none

module first_fit_chunk_allocator (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire ffca_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output ffca_pkg::rsp_t     rsp,
  input  wire logic          cfg_we,
  input  wire logic          cfg_index,
  input  wire logic [11:0]   cfg_data
);

  import ffca_pkg::*;

  state_t          state, state_next;
  req_t            req_r;
  logic [11:0]     region_start, region_size;
  logic [PW-1:0]   p, p_next;
  logic [PW-1:0]   from, from_next;
  logic [PW-1:0]   fit_end, fit_end_next;
  logic [PW-1:0]   lim, lim_next;
  logic [7:0]      head, head_next;
  logic [AW-1:0]   wa, wa_next, wa2, wa2_next;
  logic [7:0]      wd, wd_next, wd2, wd2_next;
  logic            wr2, wr2_next;
  logic [1:0]      res_status, res_status_next;
  logic [11:0]     res_addr, res_addr_next;

  logic            mem_we;
  logic [AW-1:0]   mem_wa, mem_ra;
  logic [7:0]      mem_wd, mem_rd;

  logic [PW-1:0]   start_ext, addr_ext, free_a, outer_end, rest, slack_len, data_addr;
  logic            len_bad, in_region;

  ffca_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_wa),
    .wdata (mem_wd),
    .raddr (mem_ra),
    .rdata (mem_rd)
  );

  assign start_ext = PW'(region_start);
  assign addr_ext  = PW'(req_r.address);
  assign free_a    = addr_ext - PW'(1);
  assign outer_end = p + PW'(req_r.alloc_length) + PW'(1);
  assign rest      = p - fit_end;
  assign slack_len = p - from - PW'(1);
  assign data_addr = from + PW'(1);
  assign len_bad   = (req_r.alloc_length == 7'd0) || ({1'b0, req_r.alloc_length} > MAX_ALLOC);
  assign in_region = (addr_ext > start_ext) && (addr_ext < lim);
  assign mem_ra    = (state == S_FREE_RD) ? free_a[AW-1:0] : p[AW-1:0];
  assign req_stall = (state != S_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rsp_valid    <= 1'b0;
      region_start <= 12'd1;
      region_size  <= 12'd4095;
    end else begin
      state <= state_next;
      if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
      if (cfg_we) begin
        case (cfg_index)
          REG_REGION_START: region_start <= cfg_data;
          default:          region_size  <= cfg_data;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      req_r <= req;
    end
    if (state == S_DONE && (!rsp_valid || !rsp_stall)) begin
      rsp.status        <= res_status;
      rsp.chunk_address <= res_addr;
    end
    p          <= p_next;
    from       <= from_next;
    fit_end    <= fit_end_next;
    lim        <= lim_next;
    head       <= head_next;
    wa         <= wa_next;
    wd         <= wd_next;
    wa2        <= wa2_next;
    wd2        <= wd2_next;
    wr2        <= wr2_next;
    res_status <= res_status_next;
    res_addr   <= res_addr_next;
  end

  always_comb begin
    state_next      = state;
    p_next          = p;
    from_next       = from;
    fit_end_next    = fit_end;
    lim_next        = lim;
    head_next       = head;
    wa_next         = wa;
    wd_next         = wd;
    wa2_next        = wa2;
    wd2_next        = wd2;
    wr2_next        = wr2;
    res_status_next = res_status;
    res_addr_next   = res_addr;
    mem_we          = 1'b0;
    mem_wa          = wa;
    mem_wd          = wd;
    case (state)
      S_IDLE: begin
        if (req_valid) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        res_status_next = ST_OK;
        res_addr_next   = 12'd0;
        p_next          = start_ext;
        lim_next        = start_ext + PW'(region_size);
        case (req_r.cmd)
          CMD_ALLOC: begin
            if (len_bad) begin
              res_status_next = ST_NO_SPACE;
              state_next      = S_DONE;
            end else begin
              state_next = S_OUTER;
            end
          end
          CMD_FREE: begin
            state_next = S_FREE_RD;
          end
          CMD_FORMAT: begin
            mem_we     = 1'b1;
            mem_wa     = start_ext[AW-1:0];
            mem_wd     = 8'd0;
            state_next = S_DONE;
          end
          default: begin
            mem_we     = 1'b1;
            mem_wa     = addr_ext[AW-1:0];
            mem_wd     = req_r.data_byte;
            state_next = S_DONE;
          end
        endcase
      end
      S_OUTER: begin
        // A new run of free chunks starts here; the header read is issued now.
        from_next    = p;
        fit_end_next = outer_end;
        if (outer_end < lim) begin
          state_next = S_HEAD;
        end else begin
          res_status_next = ST_NO_SPACE;
          res_addr_next   = 12'd0;
          state_next      = S_DONE;
        end
      end
      S_READ: begin
        state_next = S_HEAD;
      end
      S_HEAD: begin
        head_next  = mem_rd;
        p_next     = p + PW'(mem_rd & LEN_MASK) + PW'(1);
        state_next = S_EVAL;
      end
      S_EVAL: begin
        wa_next       = from[AW-1:0];
        wd_next       = USED_BIT | {1'b0, req_r.alloc_length};
        wa2_next      = fit_end[AW-1:0];
        wd2_next      = 8'd0;
        wr2_next      = 1'b0;
        res_addr_next = data_addr[11:0];
        if ((head & USED_BIT) != 8'd0) begin
          state_next = S_OUTER;
        end else if (head == 8'd0) begin
          // End of list: append the chunk and move the end marker behind it.
          wr2_next   = 1'b1;
          state_next = S_WRA;
        end else if (p + PW'(1) >= lim) begin
          res_status_next = ST_NO_SPACE;
          res_addr_next   = 12'd0;
          state_next      = S_DONE;
        end else if (p == fit_end) begin
          state_next = S_WRA;
        end else if (p > fit_end) begin
          if (rest < PW'(MIN_SPLIT)) begin
            wd_next = USED_BIT | (slack_len[7:0] & LEN_MASK);
          end else begin
            wr2_next = 1'b1;
            wd2_next = (rest[7:0] - 8'd1) & LEN_MASK;
          end
          state_next = S_WRA;
        end else begin
          state_next = S_READ;
        end
      end
      S_WRA: begin
        mem_we     = 1'b1;
        state_next = wr2 ? S_WRB : S_DONE;
      end
      S_WRB: begin
        mem_we     = 1'b1;
        mem_wa     = wa2;
        mem_wd     = wd2;
        state_next = S_DONE;
      end
      S_FREE_RD: begin
        if (in_region) begin
          state_next = S_FREE_HD;
        end else begin
          res_status_next = ST_OUT_REGION;
          state_next      = S_DONE;
        end
      end
      S_FREE_HD: begin
        if ((mem_rd & USED_BIT) != 8'd0) begin
          mem_we = 1'b1;
          mem_wa = free_a[AW-1:0];
          mem_wd = mem_rd & LEN_MASK;
        end else begin
          res_status_next = ST_NOT_IN_USE;
        end
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!rsp_valid || !rsp_stall) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Every header step moves the scan pointer forward past the run start.
  a_scan_advances: assert property (@(posedge clk) disable iff (rst)
    state == S_EVAL |-> p > from)
    else $error("scan pointer did not advance");

  a_fail_no_addr: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.status != ST_OK |-> rsp.chunk_address == 12'd0)
    else $error("failed command returned a chunk address");

  a_result_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> $past(state) == S_DONE)
    else $error("result loaded outside the done step");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> state == S_EXEC)
    else $error("accepted word did not start execution");

endmodule

`default_nettype wire

>>> dv/ffca_checker.sv
// Checker for the first-fit chunk allocator: watches the command, result and
// register ports, predicts each result word and compares it field by field.
// Depends on ffca_pkg for the word types, codes and sizing constants.
`timescale 1ns / 1ps

module ffca_checker (
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  input  logic             req_stall,
  input  ffca_pkg::req_t   req,
  input  logic             rsp_valid,
  input  logic             rsp_stall,
  input  ffca_pkg::rsp_t   rsp,
  input  logic             cfg_we,
  input  logic             cfg_index,
  input  logic [11:0]      cfg_data,
  output int               mismatches,
  output int               outstanding
);

  import ffca_pkg::*;

  logic [7:0]  heap_bytes [STORE_BYTES];
  logic [11:0] region_base;
  logic [11:0] region_len;
  rsp_t        awaited_replies [$];
  int          err_count;

  function automatic logic [7:0] peek(input int unsigned a);
    return heap_bytes[a[AW-1:0]];
  endfunction

  function automatic void poke(input int unsigned a, input int unsigned v);
    heap_bytes[a[AW-1:0]] = v[7:0];
  endfunction

  // Walks the chunk list from the region start, merging free runs on the way.
  function automatic bit scan_first_fit(input int unsigned len, output int unsigned data_addr);
    int unsigned p;
    int unsigned lim;
    int unsigned head;
    int unsigned from;
    int unsigned span;
    int unsigned rest;
    p = region_base;
    lim = region_base;
    lim = lim + region_len;
    data_addr = 0;
    if (len == 0 || len > MAX_ALLOC) return 1'b0;
    while (p + len + 1 < lim) begin
      from = p;
      while (1) begin
        head = peek(p);
        p = p + (head & LEN_MASK) + 1;
        if ((head & USED_BIT) != 0) break;
        if (head == 0) begin
          // End of list: append the chunk and move the end marker.
          poke(from, len | USED_BIT);
          poke(from + 1 + len, 0);
          data_addr = from + 1;
          return 1'b1;
        end
        if (p + 1 >= lim) return 1'b0;
        span = p - from;
        if (span == len + 1) begin
          poke(from, len | USED_BIT);
          data_addr = from + 1;
          return 1'b1;
        end
        if (span > len + 1) begin
          rest = span - (len + 1);
          if (rest < MIN_SPLIT) begin
            poke(from, ((span - 1) & LEN_MASK) | USED_BIT);
          end else begin
            poke(from + len + 1, (rest - 1) & LEN_MASK);
            poke(from, len | USED_BIT);
          end
          data_addr = from + 1;
          return 1'b1;
        end
      end
    end
    return 1'b0;
  endfunction

  function automatic rsp_t predict_reply(input req_t w);
    rsp_t        r;
    int unsigned data_addr;
    int unsigned lim;
    logic [7:0]  head;
    r = '0;
    case (w.cmd)
      CMD_ALLOC: begin
        if (scan_first_fit(w.alloc_length, data_addr)) r.chunk_address = data_addr[11:0];
        else r.status = ST_NO_SPACE;
      end
      CMD_FREE: begin
        lim = region_base;
        lim = lim + region_len;
        if (w.address > region_base && w.address < lim) begin
          head = peek(w.address - 1);
          if ((head & USED_BIT) != 0) poke(w.address - 1, head & LEN_MASK);
          else r.status = ST_NOT_IN_USE;
        end else begin
          r.status = ST_OUT_REGION;
        end
      end
      CMD_FORMAT: poke(region_base, 0);
      default: poke(w.address, w.data_byte);
    endcase
    return r;
  endfunction

  initial begin
    err_count = 0;
    region_base = 12'd1;
    region_len = 12'd4095;
    for (int unsigned i = 0; i < STORE_BYTES; i++) heap_bytes[i[AW-1:0]] = 8'h00;
  end

  always @(posedge clk) begin
    rsp_t want;
    if (rst) begin
      region_base = 12'd1;
      region_len = 12'd4095;
      awaited_replies.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_REGION_START) region_base = cfg_data;
        else region_len = cfg_data;
      end
      if (rsp_valid && !rsp_stall) begin
        if (awaited_replies.size() == 0) begin
          $error("result word with no command waiting: status %0d, chunk_address %0d",
                 rsp.status, rsp.chunk_address);
          err_count++;
        end else begin
          want = awaited_replies.pop_front();
          if (rsp.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, rsp.status);
            err_count++;
          end
          if (rsp.chunk_address !== want.chunk_address) begin
            $error("chunk_address: expected %0d, got %0d", want.chunk_address,
                   rsp.chunk_address);
            err_count++;
          end
        end
      end
      // A command accepted now cannot be answered in the same cycle.
      if (req_valid && !req_stall) awaited_replies.push_back(predict_reply(req));
    end
    mismatches <= err_count;
    outstanding <= awaited_replies.size();
  end

endmodule

>>> dv/testbench.sv
// Top of the allocator testbench: clock, reset, command and register stimulus,
// result-side stalls and the verdict. Depends on ffca_pkg, the allocator and
// ffca_checker, which does all prediction and comparison.
`timescale 1ns / 1ps

module testbench;

  import ffca_pkg::*;

  // Far above the slowest legal run, including full-region scans.
  localparam int unsigned CYCLE_LIMIT = 4_000_000;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        req_valid = 1'b0;
  req_t        req = '0;
  logic        rsp_stall = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [11:0] cfg_data = '0;
  logic        req_stall;
  logic        rsp_valid;
  rsp_t        rsp;
  int          mismatches;
  int          outstanding;

  logic        hold_request = 1'b0;
  logic [11:0] live_chunks [$];
  int          burst_left = 0;
  bit          steady = 1'b0;
  logic [11:0] cur_start = 12'd1;
  logic [11:0] cur_size = 12'd4095;

  first_fit_chunk_allocator u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ffca_checker u_check (
    .clk         (clk),
    .rst         (rst),
    .req_valid   (req_valid),
    .req_stall   (req_stall),
    .req         (req),
    .rsp_valid   (rsp_valid),
    .rsp_stall   (rsp_stall),
    .rsp         (rsp),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Chunks handed out so far give frees and stores realistic targets.
  always @(posedge clk) begin
    if (rsp_valid && !rsp_stall && rsp.status == ST_OK && rsp.chunk_address != 0) begin
      live_chunks.push_back(rsp.chunk_address);
    end
  end

  initial begin : receiver
    int hold_left;
    int stretch;
    int mode;
    int k;
    bit stall_now;
    hold_left = 0;
    stretch = 0;
    mode = 0;
    k = 0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        stall_now = 1'b1;
        hold_left--;
      end else if (hold_request) begin
        // Long hold-off so the block fills up and stalls its command side.
        stall_now = 1'b1;
        hold_left = 400;
        hold_request <= 1'b0;
      end else begin
        if (stretch == 0) begin
          mode = $urandom_range(0, 3);
          stretch = $urandom_range(16, 256);
        end
        stretch--;
        k++;
        case (mode)
          0: stall_now = 1'b0;
          1: stall_now = ($urandom_range(0, 99) < 30);
          2: stall_now = ($urandom_range(0, 99) < 80);
          default: stall_now = k[1];
        endcase
      end
      rsp_stall <= stall_now;
    end
  end

  function automatic req_t word_of(input logic [1:0] c, input logic [6:0] len,
                                   input logic [11:0] a, input logic [7:0] d);
    req_t w;
    w.cmd = c;
    w.alloc_length = len;
    w.address = a;
    w.data_byte = d;
    return w;
  endfunction

  task automatic offer(input req_t w);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = (steady || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 10);
      if (gap > 0) begin
        req_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    req <= w;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
  endtask

  task automatic wait_idle();
    req_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
  endtask

  task automatic set_region(input logic [11:0] s, input logic [11:0] n);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= REG_REGION_START;
    cfg_data <= s;
    @(posedge clk);
    cfg_index <= REG_REGION_SIZE;
    cfg_data <= n;
    @(posedge clk);
    cfg_we <= 1'b0;
    cur_start = s;
    cur_size = n;
    live_chunks.delete();
  endtask

  task automatic random_item();
    req_t w;
    int   r;
    int   k;
    int   idx;
    w.cmd = 2'($urandom);
    w.alloc_length = 7'($urandom);
    w.address = 12'($urandom);
    w.data_byte = 8'($urandom);
    r = $urandom_range(0, 99);
    k = $urandom_range(0, 19);
    if (r < 45) begin
      w.cmd = CMD_ALLOC;
      if (k < 14) w.alloc_length = 7'($urandom_range(1, 32));
      else if (k < 19) w.alloc_length = 7'($urandom_range(1, 124));
      else w.alloc_length = 7'($urandom_range(0, 127));
    end else if (r < 70) begin
      w.cmd = CMD_FREE;
      if (k < 14 && live_chunks.size() > 0) begin
        idx = $urandom_range(0, live_chunks.size() - 1);
        w.address = live_chunks[idx];
        // Keeping some entries gives double frees later on.
        if ($urandom_range(0, 4) != 0) live_chunks.delete(idx);
      end else if (k < 17) begin
        case ($urandom_range(0, 3))
          0: w.address = cur_start;
          1: w.address = cur_start + 12'd1;
          2: w.address = cur_start + cur_size - 12'd1;
          default: w.address = cur_start + cur_size;
        endcase
      end
    end else if (r < 95) begin
      w.cmd = CMD_STORE;
      if (live_chunks.size() > 0 && k < 15) begin
        idx = $urandom_range(0, live_chunks.size() - 1);
        w.address = live_chunks[idx] + 12'($urandom_range(0, 3));
      end
    end else begin
      w.cmd = CMD_FORMAT;
      live_chunks.delete();
    end
    offer(w);
  endtask

  initial begin : stimulus
    int unsigned n;
    int unsigned ph;
    int unsigned count;
    int unsigned i;
    logic [11:0] s;
    logic [11:0] z;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Preload the byte store with zeros, the same image the checker starts
    // from, so that no scan or free ever reads an unset byte.
    for (n = 0; n < STORE_BYTES; n++) begin
      u_dut.u_store.mem[n[AW-1:0]] = 8'h00;
    end

    // Directed part on the reset region: append, exact fit, split, absorb,
    // merging of free runs, bad lengths, double free and out-of-region frees.
    offer(word_of(CMD_FORMAT, 7'd0, 12'd0, 8'd0));
    offer(word_of(CMD_ALLOC, 7'd1, 12'd0, 8'd0));
    offer(word_of(CMD_ALLOC, 7'd124, 12'd0, 8'd0));
    offer(word_of(CMD_ALLOC, 7'd3, 12'd0, 8'd0));
    offer(word_of(CMD_FREE, 7'd0, 12'd2, 8'd0));
    offer(word_of(CMD_FREE, 7'd0, 12'd2, 8'd0));
    offer(word_of(CMD_FREE, 7'd0, 12'd1, 8'd0));
    offer(word_of(CMD_FREE, 7'd0, 12'd0, 8'd0));
    offer(word_of(CMD_ALLOC, 7'd1, 12'd0, 8'd0));
    offer(word_of(CMD_FREE, 7'd0, 12'd4, 8'd0));
    offer(word_of(CMD_ALLOC, 7'd10, 12'd0, 8'd0));
    offer(word_of(CMD_ALLOC, 7'd112, 12'd0, 8'd0));
    offer(word_of(CMD_FREE, 7'd0, 12'd2, 8'd0));
    offer(word_of(CMD_FREE, 7'd0, 12'd4, 8'd0));
    offer(word_of(CMD_ALLOC, 7'd12, 12'd0, 8'd0));
    offer(word_of(CMD_STORE, 7'd0, 12'd0, 8'h00));
    offer(word_of(CMD_STORE, 7'd127, 12'd4095, 8'hFF));
    offer(word_of(CMD_STORE, 7'd0, 12'd129, 8'hA5));
    offer(word_of(CMD_FREE, 7'd0, 12'd4095, 8'd0));
    offer(word_of(CMD_ALLOC, 7'd0, 12'd0, 8'd0));
    offer(word_of(CMD_ALLOC, 7'd125, 12'd0, 8'd0));
    offer(word_of(CMD_ALLOC, 7'd127, 12'd4095, 8'hFF));
    offer(word_of(CMD_FORMAT, 7'd0, 12'd0, 8'd0));

    // Random phases, each on its own region; the first four are the extremes.
    for (ph = 0; ph < 12; ph++) begin
      case (ph)
        0: begin s = 12'd1;    z = 12'd4095; count = 120; end
        1: begin s = 12'd4095; z = 12'd2;    count = 40;  end
        2: begin s = 12'd4000; z = 12'd300;  count = 150; end
        3: begin s = 12'd4095; z = 12'd4095; count = 60;  end
        default: begin
          s = 12'($urandom_range(1, 4095));
          z = 12'($urandom_range(16, 256));
          count = 140;
        end
      endcase
      set_region(s, z);
      steady = ($urandom_range(0, 3) == 0);
      offer(word_of(CMD_FORMAT, 7'($urandom), 12'($urandom), 8'($urandom)));
      for (i = 0; i < count; i++) begin
        if (i == count / 2 && ph % 3 == 0) hold_request <= 1'b1;
        if (i == count * 3 / 4) wait_idle();
        random_item();
      end
    end

    wait_idle();
    repeat (50) @(posedge clk);
    if (mismatches == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin : watchdog
    int unsigned ticks;
    for (ticks = 0; ticks < CYCLE_LIMIT; ticks++) @(posedge clk);
    $display("testbench: done, errors");
    $finish;
  end

endmodule
